@@ src/pfac_pkg.sv @@
// Package for the printf format argument classifier.
// Holds the request and result types, character codes and result codes.
// No dependencies.
package pfac_pkg;

    localparam int MAX_DIGITS_DEF = 24;
    localparam int CODE_BYTES_DEF = 4;

    typedef struct packed {
        logic [31:0] char_code;
        logic        end_of_format;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  arg_class;
        logic [2:0]  size_rank;
        logic [1:0]  radix;
        logic [1:0]  length_mode;
        logic [31:0] length_value;
    } t_out_item;

    typedef struct packed {
        logic        in_conversion;
        logic [1:0]  half_count;
        logic [1:0]  long_count;
        logic [4:0]  digit_count;
        logic [31:0] length_accum;
        logic        star_pending;
    } t_state;

    // argument classes
    localparam logic [3:0] CLS_SIGNED   = 4'd0;
    localparam logic [3:0] CLS_UNSIGNED = 4'd1;
    localparam logic [3:0] CLS_DOUBLE   = 4'd2;
    localparam logic [3:0] CLS_CHAR     = 4'd3;
    localparam logic [3:0] CLS_WCHAR    = 4'd4;
    localparam logic [3:0] CLS_STRING   = 4'd5;
    localparam logic [3:0] CLS_WSTRING  = 4'd6;
    localparam logic [3:0] CLS_POINTER  = 4'd7;
    localparam logic [3:0] CLS_END      = 4'd8;

    localparam logic [1:0] RADIX_DEFAULT = 2'd0;
    localparam logic [1:0] RADIX_OCTAL   = 2'd1;
    localparam logic [1:0] RADIX_HEX     = 2'd2;
    localparam logic [1:0] RADIX_TEXT    = 2'd3;

    localparam logic [1:0] LEN_ZERO_TERM = 2'd0;
    localparam logic [1:0] LEN_DIGITS    = 2'd1;
    localparam logic [1:0] LEN_STAR      = 2'd2;

    localparam logic [2:0] RANK_BASE = 3'd2;

    localparam logic [31:0] CH_PERCENT = 32'h25;
    localparam logic [31:0] CH_STAR    = 32'h2A;
    localparam logic [31:0] CH_0       = 32'h30;
    localparam logic [31:0] CH_9       = 32'h39;
    localparam logic [31:0] CH_UA      = 32'h41;
    localparam logic [31:0] CH_UC      = 32'h43;
    localparam logic [31:0] CH_UE      = 32'h45;
    localparam logic [31:0] CH_UF      = 32'h46;
    localparam logic [31:0] CH_UG      = 32'h47;
    localparam logic [31:0] CH_UL      = 32'h4C;
    localparam logic [31:0] CH_US      = 32'h53;
    localparam logic [31:0] CH_UX      = 32'h58;
    localparam logic [31:0] CH_UZ      = 32'h5A;
    localparam logic [31:0] CH_A       = 32'h61;
    localparam logic [31:0] CH_C       = 32'h63;
    localparam logic [31:0] CH_D       = 32'h64;
    localparam logic [31:0] CH_E       = 32'h65;
    localparam logic [31:0] CH_F       = 32'h66;
    localparam logic [31:0] CH_G       = 32'h67;
    localparam logic [31:0] CH_H       = 32'h68;
    localparam logic [31:0] CH_I       = 32'h69;
    localparam logic [31:0] CH_J       = 32'h6A;
    localparam logic [31:0] CH_L       = 32'h6C;
    localparam logic [31:0] CH_M       = 32'h6D;
    localparam logic [31:0] CH_N       = 32'h6E;
    localparam logic [31:0] CH_O       = 32'h6F;
    localparam logic [31:0] CH_P       = 32'h70;
    localparam logic [31:0] CH_Q       = 32'h71;
    localparam logic [31:0] CH_S       = 32'h73;
    localparam logic [31:0] CH_T       = 32'h74;
    localparam logic [31:0] CH_U       = 32'h75;
    localparam logic [31:0] CH_X       = 32'h78;
    localparam logic [31:0] CH_Z       = 32'h7A;

endpackage

@@ src/pfac_step.sv @@
// Per-character decode: next conversion state and the optional result.
// Depends on pfac_pkg.
module pfac_step
    import pfac_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF,
    parameter int CODE_BYTES = CODE_BYTES_DEF
) (
    input  t_state    i_state,
    input  t_in_item  i_item,
    output t_state    o_state,
    output logic      o_res_valid,
    output t_out_item o_res
);

    localparam logic [32:0] MaskWide = (33'd1 << (8 * CODE_BYTES)) - 33'd1;
    localparam logic [31:0] CodeMask = MaskWide[31:0];
    localparam logic [4:0]  DigitLimit = 5'(MAX_DIGITS);

    logic [31:0] ch;
    logic [2:0]  rank;
    logic [35:0] acc_times10;
    logic [35:0] acc_next;
    logic        emit;
    logic        wide_str;
    logic [3:0]  str_class;

    assign ch          = i_item.char_code & CodeMask;
    assign rank        = 3'(RANK_BASE + {1'b0, i_state.long_count}
                            - {1'b0, i_state.half_count});
    assign acc_times10 = {1'b0, i_state.length_accum, 3'b000}
                       + {3'b000, i_state.length_accum, 1'b0};
    assign acc_next    = acc_times10 + {32'd0, ch[3:0]};

    always_comb begin
        o_state     = i_state;
        o_res       = '0;
        emit        = 1'b0;
        wide_str    = 1'b0;
        str_class   = CLS_STRING;
        if (i_item.end_of_format) begin
            o_state         = '0;
            emit            = 1'b1;
            o_res.arg_class = CLS_END;
        end else if (!i_state.in_conversion) begin
            if (ch == CH_PERCENT) begin
                o_state.in_conversion = 1'b1;
            end
        end else if (ch inside {[CH_0:CH_9]}) begin
            if (i_state.digit_count < DigitLimit) begin
                o_state.length_accum = (|acc_next[35:32]) ? '1 : acc_next[31:0];
                o_state.digit_count  = i_state.digit_count + 5'd1;
            end
        end else begin
            case (ch)
                CH_STAR: begin
                    o_state.star_pending = 1'b1;
                    emit                 = 1'b1;
                    o_res.arg_class      = CLS_SIGNED;
                    o_res.size_rank      = rank;
                end
                CH_H: begin
                    if (i_state.half_count < 2'd2) begin
                        o_state.half_count = i_state.half_count + 2'd1;
                    end
                end
                CH_L: begin
                    if (i_state.long_count < 2'd2) begin
                        o_state.long_count = i_state.long_count + 2'd1;
                    end
                end
                CH_Q, CH_J: begin
                    o_state.long_count = 2'd2;
                end
                CH_UL, CH_T, CH_Z, CH_UZ: begin
                    o_state.long_count = 2'd1;
                end
                CH_D, CH_I: begin
                    o_state.in_conversion = 1'b0;
                    emit                  = 1'b1;
                    o_res.arg_class       = CLS_SIGNED;
                    o_res.size_rank       = rank;
                end
                CH_O: begin
                    o_state.in_conversion = 1'b0;
                    emit                  = 1'b1;
                    o_res.arg_class       = CLS_UNSIGNED;
                    o_res.size_rank       = rank;
                    o_res.radix           = RADIX_OCTAL;
                end
                CH_X, CH_UX: begin
                    o_state.in_conversion = 1'b0;
                    emit                  = 1'b1;
                    o_res.arg_class       = CLS_UNSIGNED;
                    o_res.size_rank       = rank;
                    o_res.radix           = RADIX_HEX;
                end
                CH_U: begin
                    o_state.in_conversion = 1'b0;
                    emit                  = 1'b1;
                    o_res.arg_class       = CLS_UNSIGNED;
                    o_res.size_rank       = rank;
                end
                CH_E, CH_UE, CH_F, CH_UF, CH_G, CH_UG, CH_A, CH_UA: begin
                    o_state.in_conversion = 1'b0;
                    emit                  = 1'b1;
                    o_res.arg_class       = CLS_DOUBLE;
                end
                CH_C: begin
                    o_state.in_conversion = 1'b0;
                    emit                  = 1'b1;
                    o_res.arg_class       = (i_state.long_count != 2'd0) ? CLS_WCHAR
                                                                         : CLS_CHAR;
                    o_res.radix           = RADIX_TEXT;
                end
                CH_UC: begin
                    o_state.in_conversion = 1'b0;
                    emit                  = 1'b1;
                    o_res.arg_class       = CLS_WCHAR;
                    o_res.radix           = RADIX_TEXT;
                end
                CH_S, CH_US: begin
                    wide_str  = (ch == CH_US) || (i_state.long_count != 2'd0);
                    str_class = wide_str ? CLS_WSTRING : CLS_STRING;
                    o_state.in_conversion = 1'b0;
                    emit                  = 1'b1;
                    o_res.arg_class       = str_class;
                    o_res.radix           = RADIX_TEXT;
                    // a pending star length wins over collected digits
                    if (i_state.star_pending) begin
                        o_state.star_pending = 1'b0;
                        o_res.length_mode    = LEN_STAR;
                    end else if (i_state.digit_count != 5'd0) begin
                        o_res.length_mode  = LEN_DIGITS;
                        o_res.length_value = i_state.length_accum;
                    end
                end
                CH_P, CH_N: begin
                    o_state.in_conversion = 1'b0;
                    emit                  = 1'b1;
                    o_res.arg_class       = CLS_POINTER;
                end
                CH_M, CH_PERCENT: begin
                    // digits survive; the size modifiers drop and the conversion ends
                    o_state.half_count    = 2'd0;
                    o_state.long_count    = 2'd0;
                    o_state.in_conversion = 1'b0;
                end
                default: begin
                end
            endcase
        end
        if (emit) begin
            o_state.half_count   = 2'd0;
            o_state.long_count   = 2'd0;
            o_state.digit_count  = 5'd0;
            o_state.length_accum = 32'd0;
        end
    end

    assign o_res_valid = emit;

endmodule

@@ src/printf_format_argument_classifier_top.sv @@
// A request goes into the input register, is decoded combinationally and its result is registered.
// Throughput: one request per cycle unless a full result register is stalled downstream.
// The input register stalls upstream only while the result register is full
// and stalled downstream. Synchronous active-low reset clears the
// conversion state and both valid flags.
module printf_format_argument_classifier_top
    import pfac_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF,
    parameter int CODE_BYTES = CODE_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_in_item,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_out_item
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    t_state    r_state;
    logic      r_out_valid;
    t_out_item r_out_item;

    t_state    n_state;
    logic      step_res_valid;
    t_out_item step_res;
    logic      out_free;
    logic      process;

    pfac_step #(
        .MAX_DIGITS (MAX_DIGITS),
        .CODE_BYTES (CODE_BYTES)
    ) u_step (
        .i_state     (r_state),
        .i_item      (r_in_item),
        .o_state     (n_state),
        .o_res_valid (step_res_valid),
        .o_res       (step_res)
    );

    assign out_free = !r_out_valid || !i_stall;
    assign process  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (!o_stall) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (process) begin
                r_state <= n_state;
            end
            if (out_free) begin
                r_out_valid <= process && step_res_valid;
            end
        end
        if (out_free && process && step_res_valid) begin
            r_out_item <= step_res;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_item = r_out_item;

    a_end_clears_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        process && r_in_item.end_of_format |=> r_state == '0)
        else $error("end of format did not clear the conversion state");

    a_end_result_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_item.arg_class == CLS_END |->
            o_out_item.size_rank == 3'd0 && o_out_item.radix == RADIX_DEFAULT &&
            o_out_item.length_mode == LEN_ZERO_TERM && o_out_item.length_value == 32'd0)
        else $error("end result carries nonzero fields");

    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.half_count <= 2'd2 && r_state.long_count <= 2'd2 &&
        r_state.digit_count <= 5'(MAX_DIGITS))
        else $error("modifier or digit count out of range");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_out_valid && i_stall)
        else $error("upstream stalled without a full pipeline");

endmodule
